// ===== hw/rtl/ps2s1_pkg.sv =====
// Shared types, constants and key map lookup functions for the set 1 scan code decoder.
package ps2s1_pkg;

    localparam logic [7:0] SC_PREFIX  = 8'hE0;
    localparam logic [7:0] SC_LCTRL   = 8'h1D;
    localparam logic [7:0] SC_LSHIFT  = 8'h2A;
    localparam logic [7:0] SC_RSHIFT  = 8'h36;
    localparam logic [7:0] SC_LALT    = 8'h38;
    localparam logic [7:0] SC_CAPS    = 8'h3A;
    localparam logic [7:0] SC_NUM     = 8'h45;
    localparam logic [7:0] SC_SCROLL  = 8'h46;
    localparam logic [7:0] SC_RCTRL   = 8'h9D;
    localparam logic [7:0] SC_RALT    = 8'hB8;

    localparam logic [7:0] K_HOME = 8'hE0;
    localparam logic [7:0] K_END  = 8'hE1;
    localparam logic [7:0] K_UP   = 8'hE2;
    localparam logic [7:0] K_DOWN = 8'hE3;
    localparam logic [7:0] K_LEFT = 8'hE4;
    localparam logic [7:0] K_RGHT = 8'hE5;
    localparam logic [7:0] K_PGUP = 8'hE6;
    localparam logic [7:0] K_PGDN = 8'hE7;
    localparam logic [7:0] K_INS  = 8'hE8;
    localparam logic [7:0] K_DEL  = 8'hE9;

    localparam logic [7:0] CASE_DELTA = 8'h20;
    localparam logic [7:0] CTRL_DELTA = 8'h60;

    typedef struct packed {
        logic esc;
        logic scroll;
        logic num;
        logic caps;
        logic alt;
        logic ctrl;
        logic shift;
    } mod_state_t;

    typedef struct packed {
        logic alt;
        logic ctrl;
        logic shift;
    } mod_bits_t;

    typedef struct packed {
        logic scroll;
        logic num;
        logic caps;
    } lock_bits_t;

    typedef struct packed {
        logic       emit;
        logic [7:0] key_char;
        mod_state_t state_next;
    } decode_t;

    function automatic mod_bits_t mod_lookup(input logic [7:0] key);
        mod_bits_t m;
        m = '0;
        case (key)
            SC_LCTRL, SC_RCTRL:   m.ctrl  = 1'b1;
            SC_LSHIFT, SC_RSHIFT: m.shift = 1'b1;
            SC_LALT, SC_RALT:     m.alt   = 1'b1;
            default:              m = '0;
        endcase
        return m;
    endfunction

    function automatic lock_bits_t lock_lookup(input logic [7:0] key);
        lock_bits_t l;
        l = '0;
        case (key)
            SC_CAPS:   l.caps   = 1'b1;
            SC_NUM:    l.num    = 1'b1;
            SC_SCROLL: l.scroll = 1'b1;
            default:   l = '0;
        endcase
        return l;
    endfunction

    function automatic logic is_lower(input logic [7:0] c);
        return (c >= 8'h61) && (c <= 8'h7A);
    endfunction

    function automatic logic is_upper(input logic [7:0] c);
        return (c >= 8'h41) && (c <= 8'h5A);
    endfunction

    // Navigation keys of the extended half; zero where there is none.
    function automatic logic [7:0] ext_lookup(input logic [7:0] key);
        logic [7:0] c;
        case (key)
            8'hC7:   c = K_HOME;
            8'hC8:   c = K_UP;
            8'hC9:   c = K_PGUP;
            8'hCB:   c = K_LEFT;
            8'hCD:   c = K_RGHT;
            8'hCF:   c = K_END;
            8'hD0:   c = K_DOWN;
            8'hD1:   c = K_PGDN;
            8'hD2:   c = K_INS;
            8'hD3:   c = K_DEL;
            default: c = 8'h00;
        endcase
        return c;
    endfunction

    function automatic logic [7:0] map_plain(input logic [7:0] key);
        logic [7:0] c;
        case (key)
            8'h01: c = 8'h1B;
            8'h02: c = 8'h31;
            8'h03: c = 8'h32;
            8'h04: c = 8'h33;
            8'h05: c = 8'h34;
            8'h06: c = 8'h35;
            8'h07: c = 8'h36;
            8'h08: c = 8'h37;
            8'h09: c = 8'h38;
            8'h0A: c = 8'h39;
            8'h0B: c = 8'h30;
            8'h0C: c = 8'h2D;
            8'h0D: c = 8'h3D;
            8'h0E: c = 8'h08;
            8'h0F: c = 8'h09;
            8'h10: c = 8'h71;
            8'h11: c = 8'h77;
            8'h12: c = 8'h65;
            8'h13: c = 8'h72;
            8'h14: c = 8'h74;
            8'h15: c = 8'h79;
            8'h16: c = 8'h75;
            8'h17: c = 8'h69;
            8'h18: c = 8'h6F;
            8'h19: c = 8'h70;
            8'h1A: c = 8'h5B;
            8'h1B: c = 8'h5D;
            8'h1C: c = 8'h0A;
            8'h1E: c = 8'h61;
            8'h1F: c = 8'h73;
            8'h20: c = 8'h64;
            8'h21: c = 8'h66;
            8'h22: c = 8'h67;
            8'h23: c = 8'h68;
            8'h24: c = 8'h6A;
            8'h25: c = 8'h6B;
            8'h26: c = 8'h6C;
            8'h27: c = 8'h3B;
            8'h28: c = 8'h27;
            8'h29: c = 8'h60;
            8'h2B: c = 8'h5C;
            8'h2C: c = 8'h7A;
            8'h2D: c = 8'h78;
            8'h2E: c = 8'h63;
            8'h2F: c = 8'h76;
            8'h30: c = 8'h62;
            8'h31: c = 8'h6E;
            8'h32: c = 8'h6D;
            8'h33: c = 8'h2C;
            8'h34: c = 8'h2E;
            8'h35: c = 8'h2F;
            8'h37: c = 8'h2A;
            8'h39: c = 8'h20;
            8'h47: c = 8'h37;
            8'h48: c = 8'h38;
            8'h49: c = 8'h39;
            8'h4A: c = 8'h2D;
            8'h4B: c = 8'h34;
            8'h4C: c = 8'h35;
            8'h4D: c = 8'h36;
            8'h4E: c = 8'h2B;
            8'h4F: c = 8'h31;
            8'h50: c = 8'h32;
            8'h51: c = 8'h33;
            8'h52: c = 8'h30;
            8'h53: c = 8'h2E;
            8'h9C: c = 8'h0A;
            8'hB5: c = 8'h2F;
            default: c = ext_lookup(key);
        endcase
        return c;
    endfunction

    // The shifted map differs from the plain one only in the symbol keys and
    // in upper case letters.
    function automatic logic [7:0] map_shift(input logic [7:0] key);
        logic [7:0] c;
        logic [7:0] p;
        p = map_plain(key);
        case (key)
            8'h02: c = 8'h21;
            8'h03: c = 8'h40;
            8'h04: c = 8'h23;
            8'h05: c = 8'h24;
            8'h06: c = 8'h25;
            8'h07: c = 8'h5E;
            8'h08: c = 8'h26;
            8'h09: c = 8'h2A;
            8'h0A: c = 8'h28;
            8'h0B: c = 8'h29;
            8'h0C: c = 8'h5F;
            8'h0D: c = 8'h2B;
            8'h1A: c = 8'h7B;
            8'h1B: c = 8'h7D;
            8'h27: c = 8'h3A;
            8'h28: c = 8'h22;
            8'h29: c = 8'h7E;
            8'h2B: c = 8'h7C;
            8'h33: c = 8'h3C;
            8'h34: c = 8'h3E;
            8'h35: c = 8'h3F;
            default: c = is_lower(p) ? (p - CASE_DELTA) : p;
        endcase
        return c;
    endfunction

    // Letter minus 0x60; enter, backslash, slash, navigation keys own codes; else zero.
    function automatic logic [7:0] map_ctrl(input logic [7:0] key);
        logic [7:0] c;
        logic [7:0] p;
        p = map_plain(key);
        case (key)
            8'h1C, 8'h9C: c = 8'h0D;
            8'h2B:        c = 8'h1C;
            8'h35, 8'hB5: c = 8'hEF;
            default:
            begin
                if (is_lower(p))
                begin
                    c = p - CTRL_DELTA;
                end
                else
                begin
                    c = ext_lookup(key);
                end
            end
        endcase
        return c;
    endfunction

endpackage

// ===== hw/rtl/ps2s1_scancode_decoder_unit.sv =====
// Top level of the set 1 scan code decoder: modifier state and result register.
// The decoder takes one set 1 scan byte per beat and can accept a new byte in
// every cycle unless a held result stalls it. Each byte is decoded in the
// cycle it is accepted, against the modifier and lock state left by the
// previous byte; a make code gives one character on the output in the next
// cycle, while prefix and break bytes only update the state. A single output
// register holds the character until it is taken, and the input stays ready
// when it is empty or emptied in the same cycle: one byte per cycle while taken.
module ps2_set1_scancode_decoder_unit
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [7:0] scan_byte,
    output logic       out_valid,
    input  logic       out_ready,
    output logic [7:0] key_char
);
    import ps2s1_pkg::*;

    mod_state_t state_reg;
    logic       out_valid_reg;
    logic       out_valid_next;
    logic [7:0] key_char_reg;
    decode_t    dec;
    logic       in_fire;

    ps2s1_decode u_decode
    (
        .scan_byte (scan_byte),
        .state_cur (state_reg),
        .dec       (dec)
    );

    assign in_ready  = !out_valid_reg || out_ready;
    assign in_fire   = in_valid && in_ready;
    assign out_valid = out_valid_reg;
    assign key_char  = key_char_reg;

    always_comb
    begin
        out_valid_next = out_valid_reg && !out_ready;
        if (in_fire && dec.emit)
        begin
            out_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            if (in_fire)
            begin
                state_reg <= dec.state_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire && dec.emit)
        begin
            key_char_reg <= dec.key_char;
        end
    end

    a_prefix_arms_escape : assert property (@(posedge clk) disable iff (!rst_n)
        in_fire && (scan_byte == SC_PREFIX) |=> state_reg.esc)
        else $error("prefix byte did not arm the escape flag");

    a_break_clears_escape : assert property (@(posedge clk) disable iff (!rst_n)
        in_fire && scan_byte[7] && (scan_byte != SC_PREFIX) |=> !state_reg.esc)
        else $error("break code left the escape flag set");

    a_make_gives_beat : assert property (@(posedge clk) disable iff (!rst_n)
        in_fire && !scan_byte[7] |=> out_valid && !state_reg.esc)
        else $error("make code gave no result beat");

    a_prefix_no_beat : assert property (@(posedge clk) disable iff (!rst_n)
        in_fire && (scan_byte == SC_PREFIX) && out_ready |=> !out_valid)
        else $error("prefix byte produced a result beat");

    a_locks_hold_on_break : assert property (@(posedge clk) disable iff (!rst_n)
        in_fire && scan_byte[7] |=>
            ($past(state_reg.caps) == state_reg.caps) &&
            ($past(state_reg.num) == state_reg.num))
        else $error("lock toggled on a break or prefix byte");

endmodule

// ===== hw/rtl/ps2s1_decode.sv =====
// Combinational decode of one scan byte against the current modifier state.
module ps2s1_decode
(
    input  logic [7:0]            scan_byte,
    input  ps2s1_pkg::mod_state_t state_cur,
    output ps2s1_pkg::decode_t    dec
);
    import ps2s1_pkg::*;

    logic       is_prefix;
    logic       is_break;
    logic [7:0] key;
    mod_bits_t  mods;
    lock_bits_t locks;
    mod_state_t made;
    logic [7:0] ch;

    // Break and make codes both index the map with the escape flag as bit 7.
    assign is_prefix = (scan_byte == SC_PREFIX);
    assign is_break  = scan_byte[7] && !is_prefix;
    assign key       = {state_cur.esc, scan_byte[6:0]};
    assign mods      = mod_lookup(key);
    assign locks     = lock_lookup(key);

    always_comb
    begin
        made        = state_cur;
        made.esc    = 1'b0;
        made.shift  = state_cur.shift | mods.shift;
        made.ctrl   = state_cur.ctrl  | mods.ctrl;
        made.alt    = state_cur.alt   | mods.alt;
        made.caps   = state_cur.caps   ^ locks.caps;
        made.num    = state_cur.num    ^ locks.num;
        made.scroll = state_cur.scroll ^ locks.scroll;
    end

    always_comb
    begin
        if (made.ctrl)
        begin
            ch = map_ctrl(key);
        end
        else if (made.shift)
        begin
            ch = map_shift(key);
        end
        else
        begin
            ch = map_plain(key);
        end
    end

    always_comb
    begin
        dec.emit       = 1'b0;
        dec.key_char   = ch;
        dec.state_next = made;
        if (is_prefix)
        begin
            dec.state_next     = state_cur;
            dec.state_next.esc = 1'b1;
        end
        else if (is_break)
        begin
            dec.state_next       = state_cur;
            dec.state_next.esc   = 1'b0;
            dec.state_next.shift = state_cur.shift & ~mods.shift;
            dec.state_next.ctrl  = state_cur.ctrl  & ~mods.ctrl;
            dec.state_next.alt   = state_cur.alt   & ~mods.alt;
        end
        else
        begin
            dec.emit = 1'b1;
            if (made.caps && is_lower(ch))
            begin
                dec.key_char = ch - CASE_DELTA;
            end
            else if (made.caps && is_upper(ch))
            begin
                dec.key_char = ch + CASE_DELTA;
            end
        end
    end

endmodule

// ===== tb/tb_ps2_set1_scancode_decoder_unit.sv =====
// Self-checking testbench for the set 1 scan code decoder: keystroke traffic against a tracker.
`timescale 1ns / 1ps

module tb_ps2_set1_scancode_decoder_unit;

    import ps2s1_pkg::*;

    // Follows the modifier and lock state of the keyboard and queues the characters
    // that the decoder owes for the make codes seen so far.
    class key_decode_tracker;
        mod_state_t  mods;
        logic [7:0]  pending_chars[$];
        int unsigned errors;

        function new();
            mods = '0;
            errors = 0;
        endfunction

        function mod_state_t held_mask(input logic [7:0] k);
            mod_state_t m;
            m = '0;
            case (k)
                SC_LCTRL, SC_RCTRL:   m.ctrl  = 1'b1;
                SC_LSHIFT, SC_RSHIFT: m.shift = 1'b1;
                SC_LALT, SC_RALT:     m.alt   = 1'b1;
                default:              m = '0;
            endcase
            return m;
        endfunction

        function mod_state_t toggle_mask(input logic [7:0] k);
            mod_state_t m;
            m = '0;
            case (k)
                SC_CAPS:   m.caps   = 1'b1;
                SC_NUM:    m.num    = 1'b1;
                SC_SCROLL: m.scroll = 1'b1;
                default:   m = '0;
            endcase
            return m;
        endfunction

        function logic [7:0] nav_char(input logic [7:0] k);
            case (k)
                8'hC7:   return K_HOME;
                8'hC8:   return K_UP;
                8'hC9:   return K_PGUP;
                8'hCB:   return K_LEFT;
                8'hCD:   return K_RGHT;
                8'hCF:   return K_END;
                8'hD0:   return K_DOWN;
                8'hD1:   return K_PGDN;
                8'hD2:   return K_INS;
                8'hD3:   return K_DEL;
                default: return 8'h00;
            endcase
        endfunction

        function logic [7:0] plain_char(input logic [7:0] k);
            logic [7:0] c;
            case (k)
                8'h01: c = 8'h1B;  8'h02: c = 8'h31;  8'h03: c = 8'h32;  8'h04: c = 8'h33;
                8'h05: c = 8'h34;  8'h06: c = 8'h35;  8'h07: c = 8'h36;  8'h08: c = 8'h37;
                8'h09: c = 8'h38;  8'h0A: c = 8'h39;  8'h0B: c = 8'h30;  8'h0C: c = 8'h2D;
                8'h0D: c = 8'h3D;  8'h0E: c = 8'h08;  8'h0F: c = 8'h09;  8'h10: c = 8'h71;
                8'h11: c = 8'h77;  8'h12: c = 8'h65;  8'h13: c = 8'h72;  8'h14: c = 8'h74;
                8'h15: c = 8'h79;  8'h16: c = 8'h75;  8'h17: c = 8'h69;  8'h18: c = 8'h6F;
                8'h19: c = 8'h70;  8'h1A: c = 8'h5B;  8'h1B: c = 8'h5D;  8'h1C: c = 8'h0A;
                8'h1E: c = 8'h61;  8'h1F: c = 8'h73;  8'h20: c = 8'h64;  8'h21: c = 8'h66;
                8'h22: c = 8'h67;  8'h23: c = 8'h68;  8'h24: c = 8'h6A;  8'h25: c = 8'h6B;
                8'h26: c = 8'h6C;  8'h27: c = 8'h3B;  8'h28: c = 8'h27;  8'h29: c = 8'h60;
                8'h2B: c = 8'h5C;  8'h2C: c = 8'h7A;  8'h2D: c = 8'h78;  8'h2E: c = 8'h63;
                8'h2F: c = 8'h76;  8'h30: c = 8'h62;  8'h31: c = 8'h6E;  8'h32: c = 8'h6D;
                8'h33: c = 8'h2C;  8'h34: c = 8'h2E;  8'h35: c = 8'h2F;  8'h37: c = 8'h2A;
                8'h39: c = 8'h20;  8'h47: c = 8'h37;  8'h48: c = 8'h38;  8'h49: c = 8'h39;
                8'h4A: c = 8'h2D;  8'h4B: c = 8'h34;  8'h4C: c = 8'h35;  8'h4D: c = 8'h36;
                8'h4E: c = 8'h2B;  8'h4F: c = 8'h31;  8'h50: c = 8'h32;  8'h51: c = 8'h33;
                8'h52: c = 8'h30;  8'h53: c = 8'h2E;  8'h9C: c = 8'h0A;  8'hB5: c = 8'h2F;
                default: c = nav_char(k);
            endcase
            return c;
        endfunction

        function logic [7:0] shift_char(input logic [7:0] k);
            logic [7:0] p;
            logic [7:0] c;
            p = plain_char(k);
            c = (p >= 8'h61 && p <= 8'h7A) ? p - 8'h20 : p;
            case (k)
                8'h02: c = 8'h21;  8'h03: c = 8'h40;  8'h04: c = 8'h23;  8'h05: c = 8'h24;
                8'h06: c = 8'h25;  8'h07: c = 8'h5E;  8'h08: c = 8'h26;  8'h09: c = 8'h2A;
                8'h0A: c = 8'h28;  8'h0B: c = 8'h29;  8'h0C: c = 8'h5F;  8'h0D: c = 8'h2B;
                8'h1A: c = 8'h7B;  8'h1B: c = 8'h7D;  8'h27: c = 8'h3A;  8'h28: c = 8'h22;
                8'h29: c = 8'h7E;  8'h2B: c = 8'h7C;  8'h33: c = 8'h3C;  8'h34: c = 8'h3E;
                8'h35: c = 8'h3F;
                default: ;
            endcase
            return c;
        endfunction

        // Only letters, enter, backslash, slash and the navigation keys survive ctrl.
        function logic [7:0] ctrl_char(input logic [7:0] k);
            logic [7:0] p;
            logic [7:0] c;
            p = plain_char(k);
            c = nav_char(k);
            if (p >= 8'h61 && p <= 8'h7A)
            begin
                c = p - 8'h60;
            end
            case (k)
                8'h1C, 8'h9C: c = 8'h0D;
                8'h2B:        c = 8'h1C;
                8'h35, 8'hB5: c = 8'hEF;
                default: ;
            endcase
            return c;
        endfunction

        function void note_scan(input logic [7:0] b);
            logic [7:0] k;
            logic [7:0] c;
            if (b == SC_PREFIX)
            begin
                mods.esc = 1'b1;
            end
            else if (b[7])
            begin
                // A plain break names its key by the low seven bits, an escaped one by all eight.
                k = mods.esc ? b : {1'b0, b[6:0]};
                mods = mod_state_t'(mods & ~held_mask(k));
                mods.esc = 1'b0;
            end
            else
            begin
                k = mods.esc ? {1'b1, b[6:0]} : b;
                mods.esc = 1'b0;
                mods = mod_state_t'(mods | held_mask(k));
                mods = mod_state_t'(mods ^ toggle_mask(k));
                if (mods.ctrl)
                begin
                    c = ctrl_char(k);
                end
                else if (mods.shift)
                begin
                    c = shift_char(k);
                end
                else
                begin
                    c = plain_char(k);
                end
                if (mods.caps && c >= 8'h61 && c <= 8'h7A)
                begin
                    c = c - 8'h20;
                end
                else if (mods.caps && c >= 8'h41 && c <= 8'h5A)
                begin
                    c = c + 8'h20;
                end
                pending_chars.push_back(c);
            end
        endfunction

        function void check_char(input logic [7:0] got);
            logic [7:0] want;
            if (pending_chars.size() == 0)
            begin
                $error("key_char: expected nothing, actual %02h", got);
                errors++;
            end
            else
            begin
                want = pending_chars.pop_front();
                if (got !== want)
                begin
                    $error("key_char: expected %02h, actual %02h", want, got);
                    errors++;
                end
            end
        endfunction
    endclass

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       in_valid = 1'b0;
    logic       in_ready;
    logic [7:0] scan_byte = 8'h00;
    logic       out_valid;
    logic       out_ready = 1'b0;
    logic [7:0] key_char;

    key_decode_tracker tracker = new();
    logic [7:0]        byte_q[$];
    bit                no_gaps = 1'b0;

    ps2_set1_scancode_decoder_unit DUT
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .scan_byte (scan_byte),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .key_char  (key_char)
    );

    always #10 clk = ~clk;

    // Entered and left at a falling edge; the beat is noted at the edge that takes it.
    task automatic send_byte(input logic [7:0] b);
        while (!no_gaps && $urandom_range(0, 99) < 34)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid  <= 1'b1;
        scan_byte <= b;
        @(posedge clk);
        while (!in_ready)
        begin
            @(posedge clk);
        end
        tracker.note_scan(b);
        @(negedge clk);
    endtask

    // One event: a modifier press or release, a lock or other key press often with its release, or a noise byte.
    function void queue_keystroke();
        int         r;
        bit         esc;
        logic [7:0] code;
        r   = $urandom_range(0, 99);
        esc = ($urandom_range(0, 99) < 20);
        if (r < 12)
        begin
            case ($urandom_range(0, 3))
                0:       code = SC_LCTRL;
                1:       code = SC_LSHIFT;
                2:       code = SC_RSHIFT;
                default: code = SC_LALT;
            endcase
            if (esc)
            begin
                byte_q.push_back(SC_PREFIX);
            end
            byte_q.push_back($urandom_range(0, 1) ? code : (code | 8'h80));
        end
        else if (r < 17)
        begin
            case ($urandom_range(0, 2))
                0:       code = SC_CAPS;
                1:       code = SC_NUM;
                default: code = SC_SCROLL;
            endcase
            byte_q.push_back(code);
            if ($urandom_range(0, 1))
            begin
                byte_q.push_back(code | 8'h80);
            end
        end
        else if (r < 85)
        begin
            code = ($urandom_range(0, 9) < 7) ? 8'($urandom_range(0, 8'h58))
                                               : 8'($urandom_range(0, 8'h7F));
            if (esc)
            begin
                byte_q.push_back(SC_PREFIX);
            end
            byte_q.push_back(code);
            if ($urandom_range(0, 1))
            begin
                if (esc)
                begin
                    byte_q.push_back(SC_PREFIX);
                end
                byte_q.push_back(code | 8'h80);
            end
        end
        else
        begin
            byte_q.push_back(8'($urandom_range(0, 255)));
        end
    endfunction

    // Result side: random back-pressure plus one long hold-off once traffic is flowing.
    initial
    begin
        int hold_left;
        int taken;
        bit held;
        hold_left = 0;
        taken     = 0;
        held      = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (out_valid && out_ready)
            begin
                tracker.check_char(key_char);
                taken++;
            end
            @(negedge clk);
            if (!held && taken >= 300)
            begin
                held      = 1'b1;
                hold_left = 150;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                out_ready <= 1'b0;
            end
            else
            begin
                out_ready <= no_gaps || ($urandom_range(0, 99) >= 34);
            end
        end
    end

    initial
    begin
        int sent;
        int guard;
        sent  = 0;
        guard = 0;
        repeat (8) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Edge values, each modifier and lock, shift with ctrl, caps, escapes and breaks.
        byte_q = '{8'h00, 8'h7F, 8'h1E, SC_LSHIFT, 8'h02, SC_LCTRL, 8'h1E, SC_RCTRL,
                   8'hAA, SC_CAPS, 8'h10, SC_NUM, SC_SCROLL, SC_LALT, 8'h1E, SC_RALT,
                   SC_CAPS, SC_PREFIX, SC_PREFIX, 8'h47, SC_PREFIX, SC_LCTRL, 8'h35,
                   SC_PREFIX, SC_RCTRL, 8'hFF, SC_PREFIX, 8'h53};
        while (byte_q.size() != 0)
        begin
            send_byte(byte_q.pop_front());
        end

        while (sent < 1700)
        begin
            queue_keystroke();
            while (byte_q.size() != 0)
            begin
                no_gaps = (sent >= 700 && sent < 1000);
                send_byte(byte_q.pop_front());
                sent++;
            end
        end
        no_gaps = 1'b0;
        in_valid <= 1'b0;

        while (tracker.pending_chars.size() != 0 && guard < 20000)
        begin
            @(posedge clk);
            guard++;
        end
        repeat (10) @(posedge clk);
        if (tracker.pending_chars.size() != 0)
        begin
            $error("key_char: %0d characters never arrived", tracker.pending_chars.size());
            tracker.errors++;
        end
        if (tracker.errors == 0)
        begin
            $display("RESULT: OK");
        end
        else
        begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

    initial
    begin
        #8000000;
        $display("RESULT: ERROR");
        $finish;
    end

endmodule
